// File: sv/smsa_pkg.sv
// Types, constants and helper functions shared by the switch motor sequencer.
// No dependencies; smsa_seq, smsa_core and the top refer to this package by scoped names.
package smsa_pkg;

  localparam int NUM_SEQ = 5;
  localparam int NUM_LINES = 12;

  // configuration register indexes
  localparam logic CFG_SLOW_BLINK = 1'b0;
  localparam logic CFG_FAST_BLINK = 1'b1;

  localparam logic [7:0] SLOW_BLINK_RESET = 8'd25;
  localparam logic [7:0] FAST_BLINK_RESET = 8'd3;

  // start sequencer step codes; other codes hold and drive nothing
  localparam logic [2:0] ST_BEGIN       = 3'd1;
  localparam logic [2:0] ST_BREAK_RELAY = 3'd2;
  localparam logic [2:0] ST_MAKE_RELAY  = 3'd3;
  localparam logic [2:0] ST_MAKE_MOS    = 3'd4;
  localparam logic [2:0] ST_DONE        = 3'd5;
  localparam logic [2:0] ST_RESTART     = 3'd6;

  // stop sequencer step codes
  localparam logic [1:0] SP_OPEN_MOS   = 2'd1;
  localparam logic [1:0] SP_OPEN_RELAY = 2'd2;
  localparam logic [1:0] SP_DONE       = 2'd3;

  // fault flag bit positions
  localparam int F_TIMEOUT = 0;
  localparam int F_OVERCUR = 1;
  localparam int F_RUN     = 2;
  localparam int F_CMD     = 3;

  typedef struct packed {
    logic [4:0] start_mask;
    logic [4:0] stop_mask;
    logic [3:0] fault_set_mask;
    logic       alarm_reset;
  } item_t;

  typedef struct packed {
    logic [11:0] drive_lines;
    logic        led_level;
    logic        alarm_relay;
    logic        alarm_latched;
    logic        timer_restart;
    logic [4:0]  active_commands;
  } result_t;

  typedef struct packed {
    logic       has_break;
    logic [3:0] brk_relay;
    logic [3:0] brk_mos;
    logic [3:0] mk_relay;
    logic [3:0] mk_mos;
    logic       restart_at4;
  } seq_desc_t;

  typedef seq_desc_t [NUM_SEQ-1:0] seq_desc_arr_t;

  // close, open, earth close, earth open, charge
  localparam seq_desc_arr_t SEQ_DESC = '{
    4: '{1'b1, 4'd10, 4'd11, 4'd8, 4'd9, 1'b1},
    3: '{1'b1, 4'd4,  4'd5,  4'd6, 4'd7, 1'b1},
    2: '{1'b1, 4'd6,  4'd7,  4'd4, 4'd5, 1'b1},
    1: '{1'b0, 4'd0,  4'd0,  4'd2, 4'd3, 1'b1},
    0: '{1'b0, 4'd0,  4'd0,  4'd0, 4'd1, 1'b0}
  };

  typedef struct packed {
    logic [7:0] count;
    logic       led;
  } blink_t;

  // one advance of the LED blink counter
  function automatic blink_t blink_step(blink_t cur, logic [7:0] period);
    blink_t res;
    res.count = cur.count + 8'd1;
    res.led   = cur.led;
    if (res.count >= period) begin
      res.count = 8'd0;
      res.led   = ~cur.led;
    end
    return res;
  endfunction

endpackage

// File: sv/smsa_if.sv
// Valid/ready channel interfaces for tick items and result items.
// Depends on smsa_pkg for nothing but field widths kept in step with it.
interface smsa_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] start_mask;
  logic [4:0] stop_mask;
  logic [3:0] fault_set_mask;
  logic       alarm_reset;

  modport source (output valid, start_mask, stop_mask, fault_set_mask, alarm_reset,
                  input ready);
  modport sink (input valid, start_mask, stop_mask, fault_set_mask, alarm_reset,
                output ready);
endinterface

interface smsa_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] drive_lines;
  logic        led_level;
  logic        alarm_relay;
  logic        alarm_latched;
  logic        timer_restart;
  logic [4:0]  active_commands;

  modport source (output valid, drive_lines, led_level, alarm_relay, alarm_latched,
                  timer_restart, active_commands, input ready);
  modport sink (input valid, drive_lines, led_level, alarm_relay, alarm_latched,
                timer_restart, active_commands, output ready);
endinterface

// File: sv/smsa_seq.sv
// One start/stop sequencer step acting on the chained drive latch word.
// Depends on smsa_pkg for step codes and the sequencer descriptor type.
module smsa_seq (
  input  smsa_pkg::seq_desc_t desc,
  input  logic                cmd_on,
  input  logic [2:0]          start_step,
  input  logic [1:0]          stop_step,
  input  logic [11:0]         lines_in,
  output logic [2:0]          start_nxt,
  output logic [1:0]          stop_nxt,
  output logic [11:0]         lines_out,
  output logic                restart
);

  always_comb begin
    start_nxt = start_step;
    stop_nxt  = stop_step;
    lines_out = lines_in;
    restart   = 1'b0;
    if (cmd_on) begin
      stop_nxt = smsa_pkg::SP_OPEN_MOS;
      case (start_step)
        smsa_pkg::ST_BEGIN: begin
          if (desc.has_break) begin
            lines_out[desc.brk_mos] = 1'b0;
            start_nxt = smsa_pkg::ST_BREAK_RELAY;
          end else begin
            lines_out[desc.mk_relay] = 1'b1;
            start_nxt = smsa_pkg::ST_MAKE_MOS;
          end
        end
        smsa_pkg::ST_BREAK_RELAY: begin
          if (desc.has_break) begin
            lines_out[desc.brk_relay] = 1'b0;
            start_nxt = smsa_pkg::ST_MAKE_RELAY;
          end
        end
        smsa_pkg::ST_MAKE_RELAY: begin
          if (desc.has_break) begin
            lines_out[desc.mk_relay] = 1'b1;
            start_nxt = smsa_pkg::ST_MAKE_MOS;
          end
        end
        smsa_pkg::ST_MAKE_MOS: begin
          lines_out[desc.mk_mos] = 1'b1;
          restart   = desc.restart_at4;
          start_nxt = smsa_pkg::ST_RESTART;
        end
        smsa_pkg::ST_RESTART: begin
          restart   = 1'b1;
          start_nxt = smsa_pkg::ST_DONE;
        end
        default: begin
        end
      endcase
    end else begin
      start_nxt = smsa_pkg::ST_BEGIN;
      case (stop_step)
        smsa_pkg::SP_OPEN_MOS: begin
          lines_out[desc.mk_mos] = 1'b0;
          stop_nxt = smsa_pkg::SP_OPEN_RELAY;
        end
        smsa_pkg::SP_OPEN_RELAY: begin
          lines_out[desc.mk_relay] = 1'b0;
          stop_nxt = smsa_pkg::SP_DONE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/smsa_core.sv
// Tick state, configuration registers, LED/fault and alarm stages, and the
// chain of five sequencers. Depends on smsa_pkg and smsa_seq.
module smsa_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              tick_en,
  input  smsa_pkg::item_t   item,
  output smsa_pkg::result_t result
);

  localparam int NS = smsa_pkg::NUM_SEQ;

  logic [7:0]  slow_r, fast_r;
  logic [4:0]  cmd_r, cmd_nxt;
  logic [3:0]  fault_r, fault_nxt;
  logic        rep_to_r, rep_to_nxt;
  logic        rep_oc_r, rep_oc_nxt;
  logic        lock_r, lock_nxt;
  logic [7:0]  blink_r;
  logic        led_r;
  logic        relay_r, relay_nxt;
  logic [11:0] drive_r;
  logic [2:0]  start_r [NS];
  logic [1:0]  stop_r [NS];

  smsa_pkg::blink_t blk;
  logic             cancel;
  logic [11:0]      lines [NS+1];
  logic [2:0]       start_in [NS];
  logic [1:0]       stop_in [NS];
  logic [2:0]       start_nxt [NS];
  logic [1:0]       stop_nxt [NS];
  logic [NS-1:0]    restarts;

  // command, LED and alarm stages, in tick order
  always_comb begin
    cmd_nxt    = (cmd_r | item.start_mask) & ~item.stop_mask;
    fault_nxt  = fault_r | item.fault_set_mask;
    rep_to_nxt = rep_to_r;
    rep_oc_nxt = rep_oc_r;
    lock_nxt   = lock_r;
    relay_nxt  = relay_r;
    blk.count  = blink_r;
    blk.led    = led_r;
    cancel     = 1'b0;

    if (fault_nxt[smsa_pkg::F_TIMEOUT]) begin
      blk    = smsa_pkg::blink_step(blk, slow_r);
      cancel = 1'b1;
    end
    if (fault_nxt[smsa_pkg::F_OVERCUR]) begin
      blk.led = 1'b1;
      cancel  = 1'b1;
    end
    if (rep_to_nxt) begin
      blk = smsa_pkg::blink_step(blk, slow_r);
    end else if (rep_oc_nxt) begin
      blk.led = 1'b1;
    end else if (fault_nxt[smsa_pkg::F_CMD] || fault_nxt[smsa_pkg::F_RUN]) begin
      blk = smsa_pkg::blink_step(blk, fast_r);
    end else begin
      blk.led   = 1'b0;
      relay_nxt = 1'b1;
    end
    if (cancel) begin
      cmd_nxt = 5'd0;
    end

    if (item.alarm_reset) begin
      relay_nxt  = 1'b1;
      fault_nxt  = 4'd0;
      lock_nxt   = 1'b0;
      rep_to_nxt = 1'b0;
      rep_oc_nxt = 1'b0;
    end else if (fault_nxt[2:0] != 3'd0) begin
      relay_nxt = 1'b0;
      if (fault_nxt[smsa_pkg::F_TIMEOUT]) begin
        if (rep_to_nxt) lock_nxt = 1'b1;
        rep_to_nxt = 1'b1;
        fault_nxt[smsa_pkg::F_TIMEOUT] = 1'b0;
      end else if (fault_nxt[smsa_pkg::F_OVERCUR]) begin
        if (rep_oc_nxt) lock_nxt = 1'b1;
        rep_oc_nxt = 1'b1;
        fault_nxt[smsa_pkg::F_OVERCUR] = 1'b0;
      end else begin
        lock_nxt = 1'b1;
      end
    end else if (fault_nxt == 4'd0 && !rep_to_nxt && !rep_oc_nxt) begin
      relay_nxt = 1'b1;
    end
  end

  assign lines[0] = drive_r;

  // sequencers run in order; earth close and earth open share latches
  for (genvar i = 0; i < NS; i++) begin : g_seq
    assign start_in[i] = cancel ? smsa_pkg::ST_BEGIN : start_r[i];
    assign stop_in[i]  = cancel ? smsa_pkg::SP_OPEN_MOS : stop_r[i];

    smsa_seq u_seq (
      .desc       (smsa_pkg::SEQ_DESC[i]),
      .cmd_on     (cmd_nxt[i]),
      .start_step (start_in[i]),
      .stop_step  (stop_in[i]),
      .lines_in   (lines[i]),
      .start_nxt  (start_nxt[i]),
      .stop_nxt   (stop_nxt[i]),
      .lines_out  (lines[i+1]),
      .restart    (restarts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r <= smsa_pkg::SLOW_BLINK_RESET;
      fast_r <= smsa_pkg::FAST_BLINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        smsa_pkg::CFG_SLOW_BLINK: slow_r <= cfg_wdata;
        smsa_pkg::CFG_FAST_BLINK: fast_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r    <= 5'd0;
      fault_r  <= 4'd0;
      rep_to_r <= 1'b0;
      rep_oc_r <= 1'b0;
      lock_r   <= 1'b0;
      blink_r  <= 8'd0;
      led_r    <= 1'b0;
      relay_r  <= 1'b0;
      drive_r  <= 12'd0;
      for (int i = 0; i < NS; i++) begin
        start_r[i] <= smsa_pkg::ST_BEGIN;
        stop_r[i]  <= smsa_pkg::SP_OPEN_MOS;
      end
    end else if (tick_en) begin
      cmd_r    <= cmd_nxt;
      fault_r  <= fault_nxt;
      rep_to_r <= rep_to_nxt;
      rep_oc_r <= rep_oc_nxt;
      lock_r   <= lock_nxt;
      blink_r  <= blk.count;
      led_r    <= blk.led;
      relay_r  <= relay_nxt;
      drive_r  <= lines[NS];
      for (int i = 0; i < NS; i++) begin
        start_r[i] <= start_nxt[i];
        stop_r[i]  <= stop_nxt[i];
      end
    end
  end

  assign result.drive_lines     = lines[NS];
  assign result.led_level       = blk.led;
  assign result.alarm_relay     = relay_nxt;
  assign result.alarm_latched   = lock_nxt;
  assign result.timer_restart   = |restarts;
  assign result.active_commands = cmd_nxt;

endmodule

// File: sv/switch_motor_sequencer_with_alarm_top.sv
// A result passes the input register, then the result register, after its tick
// transaction is accepted. Throughput: one tick per cycle unless out_ch stalls.
// The tick state update sits between the two registers and sets the rate.
// Reset (rst_n low, synchronous): both channels empty, tick state cleared,
// blink periods back to 25 and 3 ticks.
// Depends on smsa_pkg, smsa_if and smsa_core.
module switch_motor_sequencer_with_alarm_top (
  input  logic       clk,
  input  logic       rst_n,
  smsa_in_if.sink    in_ch,
  smsa_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic              s1_valid_r, s1_valid_nxt;
  smsa_pkg::item_t   s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  smsa_pkg::result_t out_res_r;
  smsa_pkg::result_t res;
  logic              out_free, s1_move, in_take;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_move  = s1_valid_r && out_free;
  // no transaction is taken while reset is held
  assign in_ch.ready = rst_n && (!s1_valid_r || out_free);
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_move) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.start_mask     <= in_ch.start_mask;
      s1_item_r.stop_mask      <= in_ch.stop_mask;
      s1_item_r.fault_set_mask <= in_ch.fault_set_mask;
      s1_item_r.alarm_reset    <= in_ch.alarm_reset;
    end
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  smsa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tick_en   (s1_move),
    .item      (s1_item_r),
    .result    (res)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_lines     = out_res_r.drive_lines;
  assign out_ch.led_level       = out_res_r.led_level;
  assign out_ch.alarm_relay     = out_res_r.alarm_relay;
  assign out_ch.alarm_latched   = out_res_r.alarm_latched;
  assign out_ch.timer_restart   = out_res_r.timer_restart;
  assign out_ch.active_commands = out_res_r.active_commands;

endmodule

// File: sv/smsa_checker.sv
// Port-level checks of the switch motor sequencer top, attached by bind.
// Depends only on the top level's ports.
module smsa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       alarm_relay,
  input logic       alarm_latched,
  input logic       timer_restart,
  input logic [4:0] active_commands
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a latched alarm always comes with the alarm relay open
  a_lock_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && alarm_latched |-> !alarm_relay)
    else $error("alarm latched with relay closed");

  // run timers restart only from an active start sequence
  a_restart_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && timer_restart |-> active_commands != 5'd0)
    else $error("timer restart without active command");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind switch_motor_sequencer_with_alarm_top smsa_checker u_smsa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .alarm_relay     (out_ch.alarm_relay),
  .alarm_latched   (out_ch.alarm_latched),
  .timer_restart   (out_ch.timer_restart),
  .active_commands (out_ch.active_commands)
);
